// ===== sv/mtep_pkg.sv =====
// Types and constants shared by the track event parser.
// No dependencies; compile first.
`default_nettype none

package mtep_pkg;

  // Longest varlen field (delta time or body length), in bytes; 1..4.
  localparam int unsigned MAX_VARLEN_BYTES = 4;

  localparam logic [1:0] KIND_CHAN  = 2'd0;
  localparam logic [1:0] KIND_META  = 2'd1;
  localparam logic [1:0] KIND_SYSEX = 2'd2;
  localparam logic [1:0] KIND_SYS   = 2'd3;

  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] STATUS_MTC_QF    = 8'hF1;
  localparam logic [7:0] STATUS_SONG_POS  = 8'hF2;
  localparam logic [7:0] STATUS_SONG_SEL  = 8'hF3;
  localparam logic [3:0] NIBBLE_SYSTEM    = 4'hF;
  localparam logic [3:0] NIBBLE_PROGRAM   = 4'hC;
  localparam logic [3:0] NIBBLE_PRESSURE  = 4'hD;
  localparam logic [7:0] META_TEMPO       = 8'h51;

  typedef enum logic [8:0] {
    PH_DELTA     = 9'b000000001,
    PH_STATUS    = 9'b000000010,
    PH_CHAN1     = 9'b000000100,
    PH_CHAN2     = 9'b000001000,
    PH_META_TYPE = 9'b000010000,
    PH_LEN       = 9'b000100000,
    PH_BODY      = 9'b001000000,
    PH_SYS1      = 9'b010000000,
    PH_SYS2      = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_word_t;

  typedef struct packed {
    logic [27:0] delta_ticks;
    logic [1:0]  event_kind;
    logic [7:0]  event_code;
    logic [3:0]  channel;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic [7:0]  third_value;
    logic [7:0]  fourth_value;
    logic [23:0] tempo_value;
  } event_t;

endpackage

`default_nettype wire

// ===== sv/mtep_in_if.sv =====
// Byte input channel of the track event parser: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

`default_nettype wire

// ===== sv/mtep_out_if.sv =====
// Event output channel of the track event parser: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] delta_ticks;
  logic [1:0]  event_kind;
  logic [7:0]  event_code;
  logic [3:0]  channel;
  logic [7:0]  first_value;
  logic [7:0]  second_value;
  logic [7:0]  third_value;
  logic [7:0]  fourth_value;
  logic [23:0] tempo_value;

  modport source (
    output valid, output delta_ticks, output event_kind, output event_code,
    output channel, output first_value, output second_value, output third_value,
    output fourth_value, output tempo_value, input ready
  );
  modport sink (
    input valid, input delta_ticks, input event_kind, input event_code,
    input channel, input first_value, input second_value, input third_value,
    input fourth_value, input tempo_value, output ready
  );
endinterface

`default_nettype wire

// ===== sv/mtep_in_stage.sv =====
// Input register of the track event parser.
// Depends on mtep_pkg and mtep_in_if.
`default_nettype none

module mtep_in_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  mtep_in_if.sink          in_ch,
  input  wire logic        take,
  output logic             valid,
  output mtep_pkg::in_word_t word
);
  import mtep_pkg::*;

  // refills in the same cycle the parser takes the held word
  assign in_ch.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word.data_byte   <= in_ch.data_byte;
      word.track_start <= in_ch.track_start;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtep_parser.sv =====
// Parse state and per-byte decode: delta time, running status, bodies.
// Depends on mtep_pkg.
`default_nettype none

module mtep_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire mtep_pkg::in_word_t word,
  input  wire logic              out_space,
  output logic                   take,
  output logic                   ev_valid,
  output mtep_pkg::event_t       ev
);
  import mtep_pkg::*;

  phase_t          phase;
  logic [7:0]      running_status;
  logic [27:0]     delta_accum;
  logic [2:0]      varlen_count;
  logic [27:0]     body_remaining;
  logic [7:0]      current_code;
  logic [3:0][7:0] captured_bytes;
  logic [2:0]      capture_index;
  logic            body_meta;

  phase_t          phase_next;
  logic [7:0]      running_status_next;
  logic [27:0]     delta_accum_next;
  logic [2:0]      varlen_count_next;
  logic [27:0]     body_remaining_next;
  logic [7:0]      current_code_next;
  logic [3:0][7:0] captured_bytes_next;
  logic [2:0]      capture_index_next;
  logic            body_meta_next;

  logic            emit;
  logic [1:0]      emit_kind;
  logic [7:0]      emit_code;
  logic [3:0]      emit_chan;
  logic            do_delta;
  logic [7:0]      b;
  logic            bodied;

  always_comb begin
    b                   = word.data_byte;
    phase_next          = phase;
    running_status_next = running_status;
    delta_accum_next    = delta_accum;
    varlen_count_next   = varlen_count;
    body_remaining_next = body_remaining;
    current_code_next   = current_code;
    captured_bytes_next = captured_bytes;
    capture_index_next  = capture_index;
    body_meta_next      = body_meta;
    emit      = 1'b0;
    emit_kind = KIND_CHAN;
    emit_code = '0;
    emit_chan = '0;
    do_delta  = 1'b0;
    bodied    = 1'b0;
    ev        = '0;

    if (word.track_start) begin
      phase_next          = PH_DELTA;
      running_status_next = '0;
      delta_accum_next    = '0;
      varlen_count_next   = '0;
      body_remaining_next = '0;
      current_code_next   = '0;
      captured_bytes_next = '0;
      capture_index_next  = '0;
      body_meta_next      = 1'b1;
    end

    case (phase_next)
      PH_DELTA: begin
        do_delta = 1'b1;
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (running_status_next == '0) begin
            // data byte with no running status: restart the delta time
            delta_accum_next    = '0;
            varlen_count_next   = '0;
            body_remaining_next = '0;
            capture_index_next  = '0;
            captured_bytes_next = '0;
            do_delta = 1'b1;
          end else begin
            current_code_next    = running_status_next;
            captured_bytes_next[0] = b;
            if (running_status_next[7:4] == NIBBLE_PROGRAM ||
                running_status_next[7:4] == NIBBLE_PRESSURE) begin
              emit      = 1'b1;
              emit_kind = KIND_CHAN;
              emit_code = {running_status_next[7:4], 4'h0};
              emit_chan = running_status_next[3:0];
            end else begin
              phase_next = PH_CHAN2;
            end
          end
        end else begin
          current_code_next = b;
          if (b[7:4] != NIBBLE_SYSTEM) begin
            running_status_next = b;
            phase_next = PH_CHAN1;
          end else if (b == STATUS_META) begin
            phase_next = PH_META_TYPE;
          end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_ESC) begin
            body_meta_next      = 1'b0;
            body_remaining_next = '0;
            varlen_count_next   = '0;
            phase_next          = PH_LEN;
          end else if (b == STATUS_MTC_QF || b == STATUS_SONG_POS ||
                       b == STATUS_SONG_SEL) begin
            phase_next = PH_SYS1;
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_SYS;
            emit_code = b;
          end
        end
      end
      PH_CHAN1: begin
        captured_bytes_next[0] = b;
        if (current_code_next[7:4] == NIBBLE_PROGRAM ||
            current_code_next[7:4] == NIBBLE_PRESSURE) begin
          emit      = 1'b1;
          emit_kind = KIND_CHAN;
          emit_code = {current_code_next[7:4], 4'h0};
          emit_chan = current_code_next[3:0];
        end else begin
          phase_next = PH_CHAN2;
        end
      end
      PH_CHAN2: begin
        captured_bytes_next[1] = b;
        emit      = 1'b1;
        emit_kind = KIND_CHAN;
        emit_code = {current_code_next[7:4], 4'h0};
        emit_chan = current_code_next[3:0];
      end
      PH_META_TYPE: begin
        current_code_next   = b;
        body_meta_next      = 1'b1;
        body_remaining_next = '0;
        varlen_count_next   = '0;
        phase_next          = PH_LEN;
      end
      PH_LEN: begin
        body_remaining_next = {body_remaining_next[20:0], b[6:0]};
        varlen_count_next   = varlen_count_next + 3'd1;
        if (!b[7] || varlen_count_next >= 3'(MAX_VARLEN_BYTES)) begin
          varlen_count_next = '0;
          if (body_remaining_next == '0) begin
            bodied = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (capture_index_next < 3'd4) begin
          captured_bytes_next[capture_index_next[1:0]] = b;
          capture_index_next = capture_index_next + 3'd1;
        end
        body_remaining_next = body_remaining_next - 28'd1;
        if (body_remaining_next == '0) begin
          bodied = 1'b1;
        end
      end
      PH_SYS1: begin
        captured_bytes_next[0] = b;
        if (current_code_next == STATUS_SONG_POS) begin
          phase_next = PH_SYS2;
        end else begin
          emit      = 1'b1;
          emit_kind = KIND_SYS;
          emit_code = current_code_next;
        end
      end
      PH_SYS2: begin
        captured_bytes_next[1] = b;
        emit      = 1'b1;
        emit_kind = KIND_SYS;
        emit_code = current_code_next;
      end
      default: begin
        delta_accum_next    = '0;
        varlen_count_next   = '0;
        body_remaining_next = '0;
        capture_index_next  = '0;
        captured_bytes_next = '0;
        do_delta = 1'b1;
      end
    endcase

    if (bodied) begin
      emit      = 1'b1;
      emit_kind = body_meta_next ? KIND_META : KIND_SYSEX;
      emit_code = current_code_next;
    end

    if (do_delta) begin
      delta_accum_next  = {delta_accum_next[20:0], b[6:0]};
      varlen_count_next = varlen_count_next + 3'd1;
      if (!b[7] || varlen_count_next >= 3'(MAX_VARLEN_BYTES)) begin
        varlen_count_next = '0;
        phase_next = PH_STATUS;
      end else begin
        phase_next = PH_DELTA;
      end
    end

    if (emit) begin
      ev.delta_ticks  = delta_accum_next;
      ev.event_kind   = emit_kind;
      ev.event_code   = emit_code;
      ev.channel      = emit_chan;
      ev.first_value  = captured_bytes_next[0];
      ev.second_value = captured_bytes_next[1];
      if (emit_kind == KIND_META || emit_kind == KIND_SYSEX) begin
        ev.third_value  = captured_bytes_next[2];
        ev.fourth_value = captured_bytes_next[3];
      end
      if (emit_kind == KIND_META && emit_code == META_TEMPO) begin
        ev.tempo_value = {captured_bytes_next[0], captured_bytes_next[1],
                          captured_bytes_next[2]};
      end
      delta_accum_next    = '0;
      varlen_count_next   = '0;
      body_remaining_next = '0;
      capture_index_next  = '0;
      captured_bytes_next = '0;
      phase_next          = PH_DELTA;
    end
  end

  // a word that yields an event waits only if the result register is full
  assign take     = in_valid && (!emit || out_space);
  assign ev_valid = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      running_status <= '0;
      delta_accum    <= '0;
      varlen_count   <= '0;
      body_remaining <= '0;
      current_code   <= '0;
      captured_bytes <= '0;
      capture_index  <= '0;
      body_meta      <= 1'b1;
    end else if (take) begin
      phase          <= phase_next;
      running_status <= running_status_next;
      delta_accum    <= delta_accum_next;
      varlen_count   <= varlen_count_next;
      body_remaining <= body_remaining_next;
      current_code   <= current_code_next;
      captured_bytes <= captured_bytes_next;
      capture_index  <= capture_index_next;
      body_meta      <= body_meta_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtep_out_stage.sv =====
// Result register of the track event parser, drives the event channel.
// Depends on mtep_pkg and mtep_out_if.
`default_nettype none

module mtep_out_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire mtep_pkg::event_t ev,
  output logic             space,
  mtep_out_if.source       out_ch
);
  import mtep_pkg::*;

  logic   valid;
  event_t held;

  assign space = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= ev;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.delta_ticks  = held.delta_ticks;
  assign out_ch.event_kind   = held.event_kind;
  assign out_ch.event_code   = held.event_code;
  assign out_ch.channel      = held.channel;
  assign out_ch.first_value  = held.first_value;
  assign out_ch.second_value = held.second_value;
  assign out_ch.third_value  = held.third_value;
  assign out_ch.fourth_value = held.fourth_value;
  assign out_ch.tempo_value  = held.tempo_value;

endmodule

`default_nettype wire

// ===== sv/midi_track_event_parser_top.sv =====
// Standard MIDI file track event parser: takes one track byte per word and
// returns one decoded event word per channel, meta, sysex or system event.
// The input is registered, decoded combinationally against the parse state
// and the event lands in a result register, so a byte is taken every cycle
// while the event side keeps up. The loop through the parse state registers
// sets that rate. A byte stalls only when it completes an event and the
// result register still holds one that has not been taken. Depends on
// mtep_pkg, the two channel interfaces, mtep_in_stage, mtep_parser and
// mtep_out_stage.
`default_nettype none

module midi_track_event_parser_top (
  input  wire logic  clk,
  input  wire logic  rst,
  mtep_in_if.sink    in_ch,
  mtep_out_if.source out_ch
);
  import mtep_pkg::*;

  logic     take;
  logic     word_valid;
  in_word_t word;
  logic     ev_valid;
  event_t   ev;
  logic     out_space;

  mtep_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .take  (take),
    .valid (word_valid),
    .word  (word)
  );

  mtep_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (word_valid),
    .word      (word),
    .out_space (out_space),
    .take      (take),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  mtep_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (ev_valid),
    .ev     (ev),
    .space  (out_space),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_take_needs_word: assert property (@(posedge clk) disable iff (rst)
    take |-> word_valid)
    else $error("parser took a word with none held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (!out_ch.valid || out_ch.ready))
    else $error("event loaded over an untaken event");

  a_chan_no_body: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.event_kind == KIND_CHAN) |->
      (out_ch.third_value == 8'd0 && out_ch.fourth_value == 8'd0 &&
       out_ch.tempo_value == 24'd0))
    else $error("channel event carries body bytes");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("event valid right after reset");
`endif

endmodule

`default_nettype wire
